// File: design/ogc_pkg.sv
// ----------------------------------------------------------------------------
// ogc_pkg: shared definitions for the online greater-count block
// Sizes, saturation limits and the item token that travels the cell chain.
// ----------------------------------------------------------------------------
package ogc_pkg;

   localparam int CAPACITY = 1024;

   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int GCOUNT_W = 10;
   localparam int RTOTAL_W = 19;
   localparam int TOTAL_W  = 20;
   localparam int SUM_W    = TOTAL_W + 1;

   localparam logic [31:0]        GCOUNT_MAX = 32'd1023;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 20'hFFFFF;
   localparam logic [TOTAL_W-1:0] RTOTAL_MAX = 20'h7FFFF;

   // One item as it moves from cell to cell.
   typedef struct packed {
      logic                    valid;
      logic                    restart;
      logic                    full;
      logic [CNT_W-1:0]        slot;
      logic [CNT_W-1:0]        hits;
      logic signed [KEY_W-1:0] key;
   } tok_type;

endpackage

// File: design/ogc_req_if.sv
// ----------------------------------------------------------------------------
// ogc_req_if: input channel
// Valid/ready channel that carries one key and its restart bit per item.
// ----------------------------------------------------------------------------
interface ogc_req_if;
   import ogc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key;
   logic                    restart;

   modport source (output valid, output key, output restart, input ready);
   modport sink   (input valid, input key, input restart, output ready);

endinterface

// File: design/ogc_rsp_if.sv
// ----------------------------------------------------------------------------
// ogc_rsp_if: result channel
// Valid/ready channel that carries the count, the running total and full flag.
// ----------------------------------------------------------------------------
interface ogc_rsp_if;
   import ogc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [GCOUNT_W-1:0]   greater_count;
   logic [RTOTAL_W-1:0]   running_total;
   logic                  full_res;

   modport source (output valid, output greater_count, output running_total,
                   output full_res, input ready);
   modport sink   (input valid, input greater_count, input running_total,
                   input full_res, output ready);

endinterface

// File: design/online_greater_count.sv
// ----------------------------------------------------------------------------
// online_greater_count: streaming inversion counter over a bounded multiset
// Each accepted item walks the whole cell row, and its result is then
// registered at the tail, where any stall on the result side holds it.
// Throughput: one item per cycle; the whole chain holds while a result waits.
// Reset: store emptied, total zeroed, pipeline drained; key slots keep junk.
// ----------------------------------------------------------------------------
module online_greater_count
   import ogc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ogc_req_if.sink   req_ch,
   ogc_rsp_if.source rsp_ch
);

   // The store is a row of CAPACITY cells, one key per cell. An item walks the
   // row one cell per cycle unless held. On entry it is given the next free
   // slot; every cell below that slot is occupied by a key of an earlier item,
   // and since items move in order at the same speed, an earlier item has
   // always written its cell before a later item reaches it. Each occupied
   // cell adds one to the item's count when its key is strictly greater, and
   // the cell that matches the slot captures the key. A restart gives the item
   // slot zero, so older keys are ignored and overwritten as new ones arrive.

   tok_type          tok_chain [CAPACITY+1];
   tok_type          entry_tok;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] eff_count;
   logic             entry_full;
   logic             advance;
   logic             accept;

   // The chain moves whenever the result register is free or being emptied.
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   always_comb begin
      eff_count  = req_ch.restart ? '0 : count_ff;
      entry_full = (eff_count == CNT_W'(CAPACITY));
      count_in   = count_ff;
      if (accept) begin
         count_in = entry_full ? eff_count : eff_count + CNT_W'(1);
      end
      entry_tok.valid   = req_ch.valid;
      entry_tok.restart = req_ch.restart;
      entry_tok.full    = entry_full;
      entry_tok.slot    = eff_count;
      entry_tok.hits    = '0;
      entry_tok.key     = req_ch.key;
   end

   assign tok_chain[0] = entry_tok;

   // The fill count lives at the entry; the cells only see it through the
   // slot number that travels with each item.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ogc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(i)),
         .up_tok     (tok_chain[i]),
         .down_tok   (tok_chain[i+1])
      );
   end

   // The tail folds the finished count into the running total in item order.
   ogc_total u_total (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .tail_tok (tok_chain[CAPACITY]),
      .rsp      (rsp_ch)
   );

   // The fill count can never pass the capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // A restart item always lands in slot zero, leaving exactly one key.
   a_restart_one : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.restart) |=> (count_ff == CNT_W'(1)))
      else $error("restart did not leave one stored key");

   // A rejected key reports no greater keys.
   a_full_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.full_res) |-> (rsp_ch.greater_count == '0))
      else $error("rejected item reports a nonzero count");

endmodule

// File: design/ogc_cell.sv
// ----------------------------------------------------------------------------
// ogc_cell: one slot of the key store
// Holds one key, counts a passing item if its key is smaller, and captures
// the item's key when the item was assigned to this slot.
// ----------------------------------------------------------------------------
module ogc_cell
   import ogc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [IDX_W-1:0]      cell_index,
   input  ogc_pkg::tok_type      up_tok,
   output ogc_pkg::tok_type      down_tok
);

   tok_type                 tok_ff;
   tok_type                 tok_in;
   logic signed [KEY_W-1:0] stored_key_ff;
   logic                    occupied;
   logic                    write_here;

   always_comb begin
      // Slots below the item's own slot were filled by earlier items.
      occupied   = up_tok.valid && !up_tok.full && (CNT_W'(cell_index) < up_tok.slot);
      write_here = up_tok.valid && !up_tok.full && (CNT_W'(cell_index) == up_tok.slot);
      tok_in     = up_tok;
      if (occupied && (stored_key_ff > $signed(up_tok.key))) begin
         tok_in.hits = up_tok.hits + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write_here) begin
         stored_key_ff <= up_tok.key;
      end
   end

   assign down_tok = tok_ff;

endmodule

// File: design/ogc_total.sv
// ----------------------------------------------------------------------------
// ogc_total: running total and result register
// Folds each finished item into the saturating total and holds the result.
// ----------------------------------------------------------------------------
module ogc_total
   import ogc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ogc_pkg::tok_type tail_tok,
   ogc_rsp_if.source        rsp
);

   logic                rsp_valid_ff;
   logic [GCOUNT_W-1:0] greater_ff;
   logic [RTOTAL_W-1:0] running_ff;
   logic                full_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic [TOTAL_W-1:0]  base_total;
   logic [SUM_W-1:0]    sum;
   logic [GCOUNT_W-1:0] greater_in;
   logic [RTOTAL_W-1:0] running_in;

   always_comb begin
      base_total = tail_tok.restart ? '0 : total_ff;
      sum        = SUM_W'(base_total) + SUM_W'(tail_tok.hits);
      if (tail_tok.full) begin
         total_in = base_total;
      end else if (sum > SUM_W'(TOTAL_MAX)) begin
         total_in = TOTAL_MAX;
      end else begin
         total_in = sum[TOTAL_W-1:0];
      end
      if (tail_tok.full) begin
         greater_in = '0;
      end else if (32'(tail_tok.hits) > GCOUNT_MAX) begin
         greater_in = GCOUNT_W'(GCOUNT_MAX);
      end else begin
         greater_in = GCOUNT_W'(tail_tok.hits);
      end
      if (total_in > RTOTAL_MAX) begin
         running_in = RTOTAL_MAX[RTOTAL_W-1:0];
      end else begin
         running_in = total_in[RTOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else if (advance) begin
         rsp_valid_ff <= tail_tok.valid;
         if (tail_tok.valid) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail_tok.valid) begin
         greater_ff <= greater_in;
         running_ff <= running_in;
         full_ff    <= tail_tok.full;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.greater_count = greater_ff;
   assign rsp.running_total = running_ff;
   assign rsp.full_res      = full_ff;

endmodule

// File: tb/sv/online_greater_count_tb.sv
// ----------------------------------------------------------------------------
// online_greater_count_tb: self-checking bench for the streaming greater-count
// Drives signed keys with restart bits through the request channel. A local
// multiset model works out the count and running total for every accepted
// item, and each response is compared in order against that model, under
// several idle and stall mixes and one long response hold-off.
// ----------------------------------------------------------------------------
module online_greater_count_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ogc_pkg::*;

   // One response as the model predicts it.
   typedef struct packed {
      logic [GCOUNT_W-1:0] greater_count;
      logic [RTOTAL_W-1:0] running_total;
      logic                full_res;
   } count_result_type;

   // Key patterns used to shape random segments. Narrow spreads produce many
   // duplicates, which is where strict comparison is easy to get wrong.
   typedef enum int unsigned {
      KEYS_ANY,
      KEYS_NARROW,
      KEYS_EXTREME,
      KEYS_CLUSTER
   } key_mix_type;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   ogc_req_if req_ch ();
   ogc_rsp_if rsp_ch ();

   online_greater_count u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Model state: the keys held since the last restart, how many there are,
   // and the running inversion total (kept at the internal 20-bit width).
   logic signed [KEY_W-1:0] held_keys [CAPACITY];
   int unsigned             held_n = 0;
   logic [TOTAL_W-1:0]      inversion_total = '0;

   // Responses still owed by the block, oldest first.
   count_result_type pending_counts [$];

   int unsigned error_count  = 0;
   int unsigned result_index = 0;

   // Idle mix for the current phase, in percent of cycles.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // The hold-off is requested by a test and counted out by a process of
   // its own. The request and served counters keep the processes from ever
   // writing the same variable.
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_len      = 0;
   int unsigned hold_left     = 0;

   // Applies one item to the model and returns the response it must produce.
   // A restart empties the multiset first, so a full store never rejects a
   // restarting key.
   function automatic count_result_type count_greater(input logic signed [KEY_W-1:0] key,
                                                      input logic restart);
      count_result_type res;
      int unsigned      hits;
      logic [SUM_W-1:0] sum;
      if (restart) begin
         held_n          = 0;
         inversion_total = '0;
      end
      if (held_n >= CAPACITY) begin
         // Store full: the key is dropped and the total is left alone.
         res.greater_count = '0;
         res.full_res      = 1'b1;
      end else begin
         hits = 0;
         for (int i = 0; i < held_n; i++) begin
            if (held_keys[i[IDX_W-1:0]] > key) hits++;
         end
         held_keys[held_n[IDX_W-1:0]] = key;
         held_n++;
         sum = SUM_W'(inversion_total + hits);
         inversion_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
         res.greater_count = (hits > GCOUNT_MAX) ? GCOUNT_MAX[GCOUNT_W-1:0]
                                                 : hits[GCOUNT_W-1:0];
         res.full_res      = 1'b0;
      end
      res.running_total = (inversion_total > RTOTAL_MAX) ? RTOTAL_MAX[RTOTAL_W-1:0]
                                                         : inversion_total[RTOTAL_W-1:0];
      return res;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   // Offers one item and returns at the edge where it is taken. Valid is
   // left high so that a following item can go out on the very next cycle;
   // it drops only for the random idle cycles in front of an item.
   task automatic send_key(input logic signed [KEY_W-1:0] key, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.key     <= key;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_counts.push_back(count_greater(key, restart));
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input key_mix_type mix);
      logic [KEY_W-1:0] k;
      case (mix)
         KEYS_NARROW:  k = $urandom_range(15) - 8;
         KEYS_EXTREME: begin
            case ($urandom_range(3))
               0:       k = KEY_MIN;
               1:       k = KEY_MAX;
               2:       k = '0;
               default: k = '1;
            endcase
         end
         KEYS_CLUSTER: k = 32'h4000_0000 + $urandom_range(300);
         default:      k = $urandom;
      endcase
      return k;
   endfunction

   // Random segments, each opened by a restart and built mostly from one key mix,
   // with a stray restart now and then in the middle of a segment.
   task automatic send_segments(input int unsigned count);
      int unsigned sent;
      int unsigned seg_len;
      key_mix_type mix;
      logic        restart;
      sent = 0;
      while (sent < count) begin
         seg_len = $urandom_range(40, 1);
         mix     = key_mix_type'($urandom_range(KEYS_CLUSTER));
         for (int j = 0; j < seg_len && sent < count; j++) begin
            restart = (j == 0) || ($urandom_range(29) == 0);
            if ($urandom_range(7) == 0) send_key(pick_key(KEYS_ANY), restart);
            else                        send_key(pick_key(mix), restart);
            sent++;
         end
      end
   endtask

   // Hand-picked keys: the signed extremes, zero and minus one, duplicates
   // that must not count as greater, and restarts in the middle of a run.
   // The first key goes in without a restart to check the empty store left
   // by reset.
   task automatic test_extremes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_key(32'sd7, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key(KEY_MAX, 1'b0);
      send_key(32'sd0, 1'b0);
      send_key(-32'sd1, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key(32'h5555_5555, 1'b0);
      send_key(32'hAAAA_AAAA, 1'b0);
      send_key(KEY_MAX, 1'b0);
      send_key(32'sd5, 1'b1);
      send_key(32'sd5, 1'b0);
      send_key(32'sd4, 1'b0);
      send_key(32'sd6, 1'b0);
      send_key(32'sd5, 1'b0);
      send_key(KEY_MAX, 1'b1);
      send_key(KEY_MAX, 1'b0);
      send_key(KEY_MIN, 1'b0);
      send_key(KEY_MIN, 1'b1);
      send_key(KEY_MAX, 1'b0);
      send_key(KEY_MIN, 1'b0);
   endtask

   task automatic test_random_runs();
      send_idle_pct = 59;
      rsp_stall_pct = 0;
      send_segments(12);
   endtask

   // Fills the store to capacity with strictly falling keys, so every key
   // beats all the ones before it and the total climbs to its largest
   // reachable value. Further keys must then be rejected with the total
   // frozen, and a restart has to be accepted even with the store full.
   task automatic test_fill_to_capacity();
      longint descent;
      send_idle_pct = 0;
      rsp_stall_pct = 59;
      descent = longint'(KEY_MAX);
      send_key(descent[KEY_W-1:0], 1'b1);
      for (int i = 1; i < CAPACITY; i++) begin
         descent = descent - longint'($urandom_range(4_000_000, 1));
         send_key(descent[KEY_W-1:0], 1'b0);
      end
      for (int i = 0; i < 4; i++) send_key(pick_key(KEYS_ANY), 1'b0);
      send_key(pick_key(KEYS_ANY), 1'b1);
      for (int i = 0; i < 3; i++) send_key(pick_key(KEYS_ANY), 1'b0);
   endtask

   task automatic test_mixed_idle();
      send_idle_pct = 32;
      rsp_stall_pct = 32;
      send_segments(12);
   endtask

   // The response side holds off well past the pipeline latency. A first
   // burst enters freely; after a pause the second burst arrives while the
   // oldest response is stuck at the output, so the chain freezes and the
   // request side has to stall until the hold-off ends.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len      <= 2 * CAPACITY + 600;
      hold_requests <= hold_requests + 1;
      send_segments(6);
      req_ch.valid <= 1'b0;
      repeat (CAPACITY + 80) @(posedge clock);
      send_segments(6);
   endtask

   // Hold-off counter: starts a requested hold-off and counts it down.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= hold_len;
      end
   end

   // Response side: checks each accepted item, then picks ready for the
   // next cycle from the hold-off counter or the current stall mix.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         count_result_type got;
         count_result_type want;
         got = '{rsp_ch.greater_count, rsp_ch.running_total, rsp_ch.full_res};
         if (pending_counts.size() == 0) begin
            note_error($sformatf("response %0d with none outstanding: %s %0d %0d %0b",
                                 result_index, "count, total, full",
                                 got.greater_count, got.running_total, got.full_res));
         end else begin
            want = pending_counts.pop_front();
            if (got.greater_count !== want.greater_count)
               note_error($sformatf("response %0d greater_count: expected %0d, got %0d",
                                    result_index, want.greater_count, got.greater_count));
            if (got.running_total !== want.running_total)
               note_error($sformatf("response %0d running_total: expected %0d, got %0d",
                                    result_index, want.running_total, got.running_total));
            if (got.full_res !== want.full_res)
               note_error($sformatf("response %0d full_res: expected %0b, got %0b",
                                    result_index, want.full_res, got.full_res));
         end
         result_index++;
      end
      if (hold_left != 0 || hold_requests != hold_served) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.key     = '0;
      req_ch.restart = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_random_runs();
      test_fill_to_capacity();
      test_mixed_idle();
      test_backpressure();

      // Drain: let every owed response arrive, then wait long enough for the
      // whole pipeline to empty again so that any stray response would show up.
      req_ch.valid <= 1'b0;
      rsp_stall_pct = 0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (CAPACITY + 64) @(posedge clock);

      if (error_count == 0 && pending_counts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
design/ogc_pkg.sv
design/ogc_req_if.sv
design/ogc_rsp_if.sv
design/ogc_cell.sv
design/ogc_total.sv
design/online_greater_count.sv
tb/sv/online_greater_count_tb.sv
